>>> hdl/bcf_pkg.sv
// Package for the boid cohesion force block: widths, register indexes, beat types.
// No dependencies.
`timescale 1ns / 1ps
package bcf_pkg;
    localparam int COORD_BITS     = 16;
    localparam int MAX_NEIGHBOURS = 1024;
    localparam int CNT_BITS       = $clog2(MAX_NEIGHBOURS) + 1;
    localparam int SUM_BITS       = COORD_BITS + CNT_BITS - 1;
    localparam int N_BITS         = SUM_BITS + 1;
    localparam int S_BITS         = 2 * SUM_BITS + 1;
    localparam int QBITS          = 15;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_ABITS     = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_FORCE  = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] self_x;
        logic [COORD_BITS-1:0] self_y;
        logic [CNT_BITS-1:0]   count;
        logic [SUM_BITS-1:0]   sum_x;
        logic [SUM_BITS-1:0]   sum_y;
    } query_t;
endpackage

>>> hdl/bcf_front.sv
// Front part: wraps deltas, tests vision radius, accumulates sums; emits a query record on last.
// Depends on bcf_pkg.
`timescale 1ns / 1ps
module bcf_front import bcf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] self_x,
    input  logic [COORD_BITS-1:0] self_y,
    input  logic [COORD_BITS-1:0] other_x,
    input  logic [COORD_BITS-1:0] other_y,
    input  logic                  nb_valid,
    input  logic                  nb_last,
    input  logic [15:0]           world_width,
    input  logic [15:0]           world_height,
    input  logic [15:0]           vision_radius,
    output logic                  q_valid,
    input  logic                  q_ready,
    output query_t                q_data
);
    // stage 1: wrapped deltas
    logic                  s1_valid_reg, s1_nb_reg, s1_last_reg;
    logic signed [17:0]    s1_dx_reg, s1_dy_reg;
    logic [COORD_BITS-1:0] s1_ox_reg, s1_oy_reg, s1_sx_reg, s1_sy_reg;
    logic signed [35:0]    dx_sq, dy_sq;
    // stage 2: squares
    logic                  s2_valid_reg, s2_nb_reg, s2_last_reg;
    logic [33:0]           s2_d2_reg;
    logic [31:0]           s2_r2_reg;
    logic [COORD_BITS-1:0] s2_ox_reg, s2_oy_reg, s2_sx_reg, s2_sy_reg;
    logic [SUM_BITS-1:0]   sum_x_reg, sum_y_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  stall;

    function automatic logic signed [17:0] wrap(input logic [15:0] o, input logic [15:0] s,
                                                input logic [15:0] w);
        logic signed [17:0] d, h;
        d = $signed({2'b00, o}) - $signed({2'b00, s});
        h = $signed({3'b000, w[15:1]});
        if (d > h) wrap = d - $signed({2'b00, w});
        else if (d < -h) wrap = d + $signed({2'b00, w});
        else wrap = d;
    endfunction

    assign stall    = s2_valid_reg && s2_last_reg && !q_ready;
    assign in_ready = !stall;
    assign dx_sq    = s1_dx_reg * s1_dx_reg;
    assign dy_sq    = s1_dy_reg * s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (!stall) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
        if (!stall) begin
            s1_nb_reg   <= nb_valid;
            s1_last_reg <= nb_last;
            s1_dx_reg   <= wrap(other_x, self_x, world_width);
            s1_dy_reg   <= wrap(other_y, self_y, world_height);
            s1_ox_reg   <= other_x;
            s1_oy_reg   <= other_y;
            s1_sx_reg   <= self_x;
            s1_sy_reg   <= self_y;
            s2_nb_reg   <= s1_nb_reg;
            s2_last_reg <= s1_last_reg;
            s2_d2_reg   <= dx_sq[33:0] + dy_sq[33:0];
            s2_r2_reg   <= vision_radius * vision_radius;
            s2_ox_reg   <= s1_ox_reg;
            s2_oy_reg   <= s1_oy_reg;
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
        end
    end

    logic                seen;
    logic [SUM_BITS-1:0] sx_next, sy_next;
    logic [CNT_BITS-1:0] count_next;
    always_comb begin
        seen = s2_nb_reg && s2_d2_reg != '0 && s2_d2_reg < {2'b00, s2_r2_reg}
             && count_reg < CNT_BITS'(MAX_NEIGHBOURS);
        sx_next    = sum_x_reg + (seen ? SUM_BITS'(s2_ox_reg) : '0);
        sy_next    = sum_y_reg + (seen ? SUM_BITS'(s2_oy_reg) : '0);
        count_next = count_reg + (seen ? CNT_BITS'(1) : '0);
    end

    assign q_valid       = s2_valid_reg && s2_last_reg;
    assign q_data.self_x = s2_sx_reg;
    assign q_data.self_y = s2_sy_reg;
    assign q_data.sum_x  = sx_next;
    assign q_data.sum_y  = sy_next;
    assign q_data.count  = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end else if (s2_valid_reg && !stall) begin
            if (s2_last_reg) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                count_reg <= '0;
            end else begin
                sum_x_reg <= sx_next;
                sum_y_reg <= sy_next;
                count_reg <= count_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_NEIGHBOURS)) else $error("count over limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_last_reg && q_ready) |=> count_reg == '0)
        else $error("count not cleared after query");
    assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(s2_d2_reg)) else $error("stage moved while stalled");
endmodule

>>> hdl/bcf_fifo.sv
// Short queue of query records between the front and back parts.
// Depends on bcf_pkg.
`timescale 1ns / 1ps
module bcf_fifo import bcf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  query_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output query_t rd_data
);
    query_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_ABITS:0]   wptr_reg, rptr_reg;
    logic                  wr_en, rd_en;

    assign wr_ready = (wptr_reg - rptr_reg) != (FIFO_ABITS+1)'(FIFO_DEPTH);
    assign rd_valid = wptr_reg != rptr_reg;
    assign rd_data  = mem_reg[rptr_reg[FIFO_ABITS-1:0]];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (wr_en) wptr_reg <= wptr_reg + 1'b1;
            if (rd_en) rptr_reg <= rptr_reg + 1'b1;
        end
        if (wr_en) mem_reg[wptr_reg[FIFO_ABITS-1:0]] <= wr_data;
    end
endmodule

>>> hdl/bcf_back.sv
// Back part: forms the scaled delta and finds each force component bit by bit.
// Depends on bcf_pkg.
`timescale 1ns / 1ps
module bcf_back import bcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  query_t      q_data,
    input  logic [14:0] max_force,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] force_x,
    output logic [15:0] force_y,
    output logic        none_seen
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_RLO  = 3'd4;
    localparam logic [2:0] ST_RHI  = 3'd5;
    localparam logic [2:0] ST_BIT  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam int P_BITS = 2 * QBITS + S_BITS;
    localparam int H_BITS = 2 * QBITS + SUM_BITS;

    logic [2:0]              state_reg;
    query_t                  q_reg;
    logic signed [N_BITS-1:0] nx_reg, ny_reg;
    logic [SUM_BITS-1:0]     ax_reg, ay_reg;
    logic [S_BITS-1:0]       s_reg;
    logic [2*SUM_BITS-1:0]   xx_reg, yy_reg;
    logic [P_BITS-1:0]       rx_reg, ry_reg;
    logic [P_BITS-1:0]       qqs_x_reg, qqs_y_reg, qs_x_reg, qs_y_reg;
    logic [QBITS-1:0]        qx_reg, qy_reg;
    logic [3:0]              bit_reg;
    logic [29:0]             mm_reg;

    // rhs: m^2 * n^2 in two halves ; lhs: cand^2 * s kept by shift and add
    logic [QBITS-1:0]  cx, cy;
    logic [P_BITS-1:0] lx, ly, nsx, nsy;
    logic [H_BITS-1:0] plx, ply, phx, phy;
    always_comb begin
        cx  = qx_reg | (QBITS'(1) << bit_reg);
        cy  = qy_reg | (QBITS'(1) << bit_reg);
        lx  = qqs_x_reg + (qs_x_reg << (bit_reg + 4'd1))
            + (P_BITS'(s_reg) << {bit_reg, 1'b0});
        ly  = qqs_y_reg + (qs_y_reg << (bit_reg + 4'd1))
            + (P_BITS'(s_reg) << {bit_reg, 1'b0});
        nsx = qs_x_reg + (P_BITS'(s_reg) << bit_reg);
        nsy = qs_y_reg + (P_BITS'(s_reg) << bit_reg);
        plx = mm_reg * xx_reg[SUM_BITS-1:0];
        ply = mm_reg * yy_reg[SUM_BITS-1:0];
        phx = mm_reg * xx_reg[2*SUM_BITS-1:SUM_BITS];
        phy = mm_reg * yy_reg[2*SUM_BITS-1:SUM_BITS];
    end

    assign q_ready = state_reg == ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: if (q_valid) begin
                    q_reg     <= q_data;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    nx_reg <= $signed({1'b0, q_reg.sum_x})
                            - $signed({1'b0, SUM_BITS'(q_reg.count * q_reg.self_x)});
                    ny_reg <= $signed({1'b0, q_reg.sum_y})
                            - $signed({1'b0, SUM_BITS'(q_reg.count * q_reg.self_y)});
                    mm_reg <= max_force * max_force;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    ax_reg <= nx_reg[N_BITS-1] ? SUM_BITS'(-nx_reg) : SUM_BITS'(nx_reg);
                    ay_reg <= ny_reg[N_BITS-1] ? SUM_BITS'(-ny_reg) : SUM_BITS'(ny_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    xx_reg <= ax_reg * ax_reg;
                    yy_reg <= ay_reg * ay_reg;
                    state_reg <= ST_RLO;
                end
                ST_RLO: begin
                    s_reg  <= S_BITS'(xx_reg) + S_BITS'(yy_reg);
                    rx_reg <= P_BITS'(plx);
                    ry_reg <= P_BITS'(ply);
                    state_reg <= ST_RHI;
                end
                ST_RHI: begin
                    rx_reg <= rx_reg + (P_BITS'(phx) << SUM_BITS);
                    ry_reg <= ry_reg + (P_BITS'(phy) << SUM_BITS);
                    bit_reg <= 4'd14;
                    qx_reg <= '0;
                    qy_reg <= '0;
                    qqs_x_reg <= '0;
                    qqs_y_reg <= '0;
                    qs_x_reg <= '0;
                    qs_y_reg <= '0;
                    state_reg <= ST_BIT;
                end
                ST_BIT: begin
                    if (lx <= rx_reg) begin
                        qx_reg    <= cx;
                        qqs_x_reg <= lx;
                        qs_x_reg  <= nsx;
                    end
                    if (ly <= ry_reg) begin
                        qy_reg    <= cy;
                        qqs_y_reg <= ly;
                        qs_y_reg  <= nsy;
                    end
                    if (bit_reg == 4'd0) state_reg <= ST_OUT;
                    else bit_reg <= bit_reg - 4'd1;
                end
                ST_OUT: if (!m_valid) begin
                    m_valid <= 1'b1;
                    if (q_reg.count == '0 || s_reg == '0) begin
                        force_x <= '0;
                        force_y <= '0;
                    end else begin
                        force_x <= nx_reg[N_BITS-1] ? -{1'b0, qx_reg} : {1'b0, qx_reg};
                        force_y <= ny_reg[N_BITS-1] ? -{1'b0, qy_reg} : {1'b0, qy_reg};
                    end
                    none_seen <= q_reg.count == '0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (m_valid && m_ready) m_valid <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> state_reg == ST_MUL) else $error("query not taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && none_seen) |-> (force_x == '0 && force_y == '0))
        else $error("force with nothing seen");
endmodule

>>> hdl/boid_cohesion_force.sv
// Top level of the boid cohesion force block: APB registers, front, queue and back parts.
// Depends on bcf_pkg, bcf_front, bcf_fifo, bcf_back.
`timescale 1ns / 1ps
// One neighbour beat is taken per cycle unless a query record waits on a full queue;
// the front runs a two-stage wrap and radius test and keeps the running sums. A
// beat with tlast sends a query record through a four-entry queue to the back part,
// which takes one query at a time (setup, squares, a two-step wide product, 15 steps
// of a bit-serial root search, output). Beats keep flowing while the back works until
// the queue fills. Results appear only for beats marked tlast.
module boid_cohesion_force import bcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // self_x, self_y, other_x, other_y
    input  logic        s_tuser,  // neighbour_valid
    input  logic        s_tlast,  // last_neighbour
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // force_x, force_y
    output logic        m_tuser,  // none_seen
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] world_width_reg, world_height_reg, vision_radius_reg;
    logic [14:0] max_force_reg;
    logic        q_valid, q_ready, b_valid, b_ready;
    query_t      q_data, b_data;
    logic [15:0] fx, fy;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_width_reg   <= 16'd30720;
            world_height_reg  <= 16'd17280;
            vision_radius_reg <= 16'd160;
            max_force_reg     <= 15'd16;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:  world_width_reg   <= pwdata[15:0];
                REG_HEIGHT: world_height_reg  <= pwdata[15:0];
                REG_RADIUS: vision_radius_reg <= pwdata[15:0];
                REG_FORCE:  max_force_reg     <= pwdata[14:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {16'd0, world_width_reg};
            REG_HEIGHT: prdata = {16'd0, world_height_reg};
            REG_RADIUS: prdata = {16'd0, vision_radius_reg};
            REG_FORCE:  prdata = {17'd0, max_force_reg};
            default:    prdata = '0;
        endcase
    end

    bcf_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .self_x(s_tdata[15:0]), .self_y(s_tdata[31:16]),
        .other_x(s_tdata[47:32]), .other_y(s_tdata[63:48]),
        .nb_valid(s_tuser), .nb_last(s_tlast),
        .world_width(world_width_reg), .world_height(world_height_reg),
        .vision_radius(vision_radius_reg),
        .q_valid, .q_ready, .q_data
    );

    bcf_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(q_valid), .wr_ready(q_ready), .wr_data(q_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    bcf_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .max_force(max_force_reg),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .force_x(fx), .force_y(fy), .none_seen(m_tuser)
    );
    assign m_tdata = {fy, fx};
endmodule
